FILE: design/mvr_pkg.sv
`timescale 1ns / 1ps
package mvr_pkg;

  localparam int CHANNELS = 3;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);
  localparam int LEN_W = 26;
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] STEP_RESET = 16'd150;
  localparam logic [6:0] MAX_VOL = 7'd100;
  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_FADE   = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_e;

  typedef enum logic {
    ACT_SET  = 1'b0,
    ACT_STOP = 1'b1
  } act_e;

  typedef enum logic [3:0] {
    B_IDLE, B_DISP, B_TLOAD, B_TEVAL, B_MUL, B_DIV, B_TCMP,
    B_E0, B_E1, B_E2, B_SETV, B_FROM, B_FIN
  } back_state_e;

  // One classified command as it waits between the front and the back.
  typedef struct packed {
    cmd_e             kind;
    logic [CH_W-1:0]  ch;
    logic [31:0]      now;
    logic [6:0]       lvl_a;   // set level, or fade start level
    logic [6:0]       lvl_b;   // fade end level
    logic [LEN_W-1:0] len;     // fade length in ms
    logic             stop;
    logic [6:0]       rest;
    logic [6:0]       pvol;    // fallback current volume from the poll
  } entry_t;

  typedef struct packed {
    act_e       action;
    logic [1:0] ch;
    logic [6:0] level;
  } result_t;

  function automatic logic [6:0] clamp_vol(input logic signed [10:0] v);
    logic [6:0] r;
    if (v < 0) r = 7'd0;
    else if (v > 11'sd100) r = MAX_VOL;
    else r = v[6:0];
    return r;
  endfunction

endpackage

FILE: design/mvr_queue.sv
`timescale 1ns / 1ps
module mvr_queue import mvr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o,
  output logic   full_o
);

  entry_t          mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QP_W:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QP_W+1)'(QUEUE_DEPTH));
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: design/mvr_front.sv
`timescale 1ns / 1ps
module mvr_front import mvr_pkg::*; (
  input  logic               valid_i,
  output logic               ready_o,
  input  cmd_e               cmd_i,
  input  logic [1:0]         channel_i,
  input  logic [31:0]        now_ms_i,
  input  logic signed [10:0] level_i,
  input  logic signed [10:0] start_level_i,
  input  logic signed [10:0] end_level_i,
  input  logic [15:0]        duration_seconds_i,
  input  logic               stop_at_end_i,
  input  logic [6:0]         restore_level_i,
  input  logic [6:0]         polled_volume_i,
  input  logic               full_i,
  output logic               push_o,
  output entry_t             entry_o
);

  logic ch_ok;

  assign ch_ok   = ({3'b000, channel_i} < CH_LIMIT);
  assign ready_o = !full_i;
  // Commands for a missing channel are taken and dropped here.
  assign push_o  = valid_i && !full_i && (cmd_i == CMD_TICK || ch_ok);

  always_comb begin
    entry_o.kind  = cmd_i;
    entry_o.ch    = CH_W'(channel_i);
    entry_o.now   = now_ms_i;
    entry_o.lvl_a = (cmd_i == CMD_SET) ? clamp_vol(level_i) : clamp_vol(start_level_i);
    entry_o.lvl_b = clamp_vol(end_level_i);
    entry_o.len   = LEN_W'(duration_seconds_i) * LEN_W'(MS_PER_S);
    entry_o.stop  = stop_at_end_i;
    entry_o.rest  = (restore_level_i > MAX_VOL) ? MAX_VOL : restore_level_i;
    if (polled_volume_i == 7'd0) entry_o.pvol = MAX_VOL;
    else if (polled_volume_i > MAX_VOL) entry_o.pvol = MAX_VOL;
    else entry_o.pvol = polled_volume_i;
  end

endmodule

FILE: design/mvr_back.sv
`timescale 1ns / 1ps
module mvr_back import mvr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      entry_i,
  output logic        pop_o,
  input  logic [15:0] step_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_res_o,
  output logic        out_last_o
);

  back_state_e state_q, state_d;

  entry_t          item_q;
  logic [CH_W-1:0] cidx_q;

  logic             act_q   [CHANNELS];
  logic             setv_q  [CHANNELS];
  logic [6:0]       setl_q  [CHANNELS];
  logic [6:0]       from_q  [CHANNELS];
  logic [6:0]       to_q    [CHANNELS];
  logic [31:0]      start_q [CHANNELS];
  logic [LEN_W-1:0] len_q   [CHANNELS];
  logic [31:0]      next_q  [CHANNELS];
  logic [6:0]       lsent_q [CHANNELS];
  logic             stops_q [CHANNELS];
  logic [6:0]       rest_q  [CHANNELS];

  logic [31:0] elapsed_q;
  logic [32:0] rem_q;
  logic        neg_q;
  logic [6:0]  quo_q;
  logic [2:0]  k_q;
  logic [6:0]  seq_to_q, seq_rest_q;
  logic        seq_stop_q;

  logic    pend_v_q, ov_q;
  result_t pend_q, out_q;
  logic    olast_q;

  logic       last_ch, elapsed_ge, early, div_ge, out_free, emit_ok;
  logic       emit_req, emit_do, fin_move, inc_ch;
  result_t    emit_res;
  logic [6:0] curvol, vclamp, mag;
  logic [7:0] diff;
  logic [8:0] vsum;
  logic [32:0] shifted;
  back_state_e adv_state, done_state;

  assign last_ch    = (cidx_q == CH_W'(CHANNELS - 1));
  assign elapsed_ge = (elapsed_q >= 32'(len_q[cidx_q]));
  assign early      = (item_q.now < next_q[cidx_q]);
  assign shifted    = 33'(len_q[cidx_q]) << k_q;
  assign div_ge     = (rem_q >= shifted);
  assign curvol     = setv_q[cidx_q] ? setl_q[cidx_q] : item_q.pvol;
  assign diff       = {1'b0, to_q[cidx_q]} - {1'b0, from_q[cidx_q]};
  assign mag        = diff[7] ? 7'(-diff) : diff[6:0];
  assign vsum       = neg_q ? ({2'b00, from_q[cidx_q]} - {2'b00, quo_q})
                            : ({2'b00, from_q[cidx_q]} + {2'b00, quo_q});
  assign vclamp     = vsum[8] ? 7'd0 : ((vsum > 9'(MAX_VOL)) ? MAX_VOL : vsum[6:0]);
  assign out_free   = !ov_q || out_ready_i;
  assign emit_ok    = !pend_v_q || out_free;
  assign emit_do    = emit_req && emit_ok;
  assign adv_state  = last_ch ? B_FIN : B_TLOAD;
  assign done_state = (item_q.kind == CMD_TICK) ? adv_state : B_FIN;

  assign out_valid_o = ov_q;
  assign out_res_o   = out_q;
  assign out_last_o  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    emit_req = 1'b0;
    emit_res = '{action: ACT_SET, ch: 2'(cidx_q), level: 7'd0};
    fin_move = 1'b0;
    inc_ch   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_DISP;
        end
      end
      B_DISP: begin
        unique case (item_q.kind)
          CMD_TICK:   state_d = B_TLOAD;
          CMD_SET:    state_d = B_SETV;
          CMD_CANCEL: state_d = B_FIN;
          CMD_FADE: begin
            if (item_q.len == '0) state_d = B_E0;
            else if (item_q.lvl_a != curvol) state_d = B_FROM;
            else state_d = B_FIN;
          end
        endcase
      end
      B_TLOAD: begin
        if (act_q[cidx_q]) state_d = B_TEVAL;
        else begin
          state_d = adv_state;
          inc_ch  = !last_ch;
        end
      end
      B_TEVAL: begin
        if (elapsed_ge) state_d = B_E0;
        else if (early) begin
          state_d = adv_state;
          inc_ch  = !last_ch;
        end else state_d = B_MUL;
      end
      B_MUL: state_d = B_DIV;
      B_DIV: if (k_q == 3'd0) state_d = B_TCMP;
      B_TCMP: begin
        if (vclamp != lsent_q[cidx_q]) begin
          emit_req       = 1'b1;
          emit_res.level = vclamp;
          if (emit_ok) begin
            state_d = adv_state;
            inc_ch  = !last_ch;
          end
        end else begin
          state_d = adv_state;
          inc_ch  = !last_ch;
        end
      end
      B_E0: begin
        emit_req       = 1'b1;
        emit_res.level = seq_to_q;
        if (emit_ok) begin
          state_d = seq_stop_q ? B_E1 : done_state;
          inc_ch  = !seq_stop_q && item_q.kind == CMD_TICK && !last_ch;
        end
      end
      B_E1: begin
        emit_req        = 1'b1;
        emit_res.action = ACT_STOP;
        if (emit_ok) state_d = B_E2;
      end
      B_E2: begin
        emit_req       = 1'b1;
        emit_res.level = seq_rest_q;
        if (emit_ok) begin
          state_d = done_state;
          inc_ch  = item_q.kind == CMD_TICK && !last_ch;
        end
      end
      B_SETV, B_FROM: begin
        emit_req       = 1'b1;
        emit_res.level = item_q.lvl_a;
        if (emit_ok) state_d = B_FIN;
      end
      B_FIN: begin
        if (!pend_v_q) state_d = B_IDLE;
        else if (out_free) begin
          fin_move = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Channel state: the active-fade and settled-volume flags and the channel index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        act_q[i]  <= 1'b0;
        setv_q[i] <= 1'b0;
      end
      cidx_q <= '0;
    end else begin
      if (inc_ch) cidx_q <= cidx_q + 1'b1;
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) cidx_q <= (entry_i.kind == CMD_TICK) ? '0 : entry_i.ch;
        end
        B_DISP: begin
          // Any channel command ends the running fade; a timed fade starts anew.
          if (item_q.kind != CMD_TICK) begin
            act_q[cidx_q] <= (item_q.kind == CMD_FADE && item_q.len != '0);
          end
        end
        B_E0: begin
          if (emit_do && !seq_stop_q) begin
            setv_q[cidx_q] <= 1'b1;
            act_q[cidx_q]  <= 1'b0;
          end
        end
        B_E2, B_SETV: begin
          if (emit_do) begin
            setv_q[cidx_q] <= 1'b1;
            act_q[cidx_q]  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: if (pop_o) item_q <= entry_i;
      B_DISP: begin
        seq_to_q   <= item_q.lvl_b;
        seq_stop_q <= item_q.stop;
        seq_rest_q <= item_q.rest;
        if (item_q.kind == CMD_FADE && item_q.len != '0) begin
          from_q[cidx_q]  <= item_q.lvl_a;
          to_q[cidx_q]    <= item_q.lvl_b;
          start_q[cidx_q] <= item_q.now;
          len_q[cidx_q]   <= item_q.len;
          next_q[cidx_q]  <= '0;
          lsent_q[cidx_q] <= item_q.lvl_a;
          stops_q[cidx_q] <= item_q.stop;
          rest_q[cidx_q]  <= item_q.rest;
        end
      end
      B_TLOAD: elapsed_q <= item_q.now - start_q[cidx_q];
      B_TEVAL: begin
        seq_to_q   <= to_q[cidx_q];
        seq_stop_q <= stops_q[cidx_q];
        seq_rest_q <= rest_q[cidx_q];
        if (!elapsed_ge && !early) next_q[cidx_q] <= item_q.now + 32'(step_ms_i);
      end
      B_MUL: begin
        rem_q <= 33'(mag) * 33'(elapsed_q[LEN_W-1:0]);
        neg_q <= diff[7];
        quo_q <= '0;
        k_q   <= 3'd6;
      end
      B_DIV: begin
        if (div_ge) begin
          rem_q      <= rem_q - shifted;
          quo_q[k_q] <= 1'b1;
        end
        k_q <= k_q - 1'b1;
      end
      B_TCMP: if (emit_do) lsent_q[cidx_q] <= vclamp;
      B_E0: if (emit_do && !seq_stop_q) setl_q[cidx_q] <= seq_to_q;
      B_E2: if (emit_do) setl_q[cidx_q] <= seq_rest_q;
      B_SETV: if (emit_do) setl_q[cidx_q] <= item_q.lvl_a;
      default: ;
    endcase
  end

  // A result waits in the pending slot until the next one or the end of the
  // item decides whether it is the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if ((emit_do && pend_v_q) || fin_move) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (emit_do) pend_v_q <= 1'b1;
      else if (fin_move) pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((emit_do && pend_v_q) || fin_move) begin
      out_q   <= pend_q;
      olast_q <= fin_move;
    end
    if (emit_do) pend_q <= emit_res;
  end

endmodule

FILE: design/multichannel_volume_ramp.sv
`timescale 1ns / 1ps
// Volume fade controller for CHANNELS audio channels.
// Commands arrive on the s_axis channel: tuser carries the command (tick, set
// volume, start fade, cancel fade) and tdata the operands. Each command
// yields zero to nine result items on m_axis: tuser is the action (set
// volume or stop playback), tdata the channel and level, and tlast marks the
// final result of a command. A command that yields nothing raises no tlast.
// A front stage classifies commands into a two-entry queue; the back stage
// executes one command at a time against the per-channel fade state.
// A tick visits every channel in turn: an idle channel and one still inside its
// step interval are passed over, a finishing fade emits its end level (then the
// stop and the restore if asked), and an intermediate step forms the
// interpolated level with a 7-step restoring divider. Each result is held back
// one slot until tlast is known.
// The fade step interval sits in APB register 0 (reset 150 ms).
// Reset clears all fades and marks each settled volume as unknown.
// When the receiver stalls, the back stage halts with its result held, and
// the queue keeps taking commands until it fills.
module multichannel_volume_ramp import mvr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // channel[1:0], now_ms[33:2], level[44:34], start_level[55:45],
  // end_level[66:56], duration_seconds[82:67], stop_at_end[83],
  // restore_level[90:84], polled_volume[97:91], zero fill above
  input  logic [103:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_channel[1:0], out_level[8:2], zero fill above
  output logic [15:0]  m_axis_tdata_o,
  // action[0]
  output logic         m_axis_tuser_o,
  output logic         m_axis_tlast_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] step_q;
  logic        q_push, q_pop, q_empty, q_full;
  entry_t      q_in, q_out;
  result_t     res;
  logic        res_last;

  // Configuration: only register 0, the fade step interval.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, step_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= STEP_RESET;
    else if (psel && penable && pwrite && paddr[2] == 1'b0) step_q <= pwdata[15:0];
  end

  mvr_front u_front (
    .valid_i            (s_axis_tvalid_i),
    .ready_o            (s_axis_tready_o),
    .cmd_i              (cmd_e'(s_axis_tuser_i)),
    .channel_i          (s_axis_tdata_i[1:0]),
    .now_ms_i           (s_axis_tdata_i[33:2]),
    .level_i            (s_axis_tdata_i[44:34]),
    .start_level_i      (s_axis_tdata_i[55:45]),
    .end_level_i        (s_axis_tdata_i[66:56]),
    .duration_seconds_i (s_axis_tdata_i[82:67]),
    .stop_at_end_i      (s_axis_tdata_i[83]),
    .restore_level_i    (s_axis_tdata_i[90:84]),
    .polled_volume_i    (s_axis_tdata_i[97:91]),
    .full_i             (q_full),
    .push_o             (q_push),
    .entry_o            (q_in)
  );

  mvr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  mvr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .entry_i     (q_out),
    .pop_o       (q_pop),
    .step_ms_i   (step_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res),
    .out_last_o  (res_last)
  );

  assign m_axis_tdata_o = {7'd0, res.level, res.ch};
  assign m_axis_tuser_o = res.action;
  assign m_axis_tlast_o = res_last;

  // A stop is always followed by the restore write, so it never ends a command.
  a_stop_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.action == ACT_STOP) |-> !m_axis_tlast_o)
    else $error("stop result marked last");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res.level <= MAX_VOL))
    else $error("result level above range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

endmodule
